@@ design/fpa_pkg.sv @@
// Package for the fixed-point ALU: operation codes, widths and the per-stage
// record carried down the pipeline of divider cells. No dependencies.
package fpa_pkg;

   localparam int WordWidth    = 32;
   localparam int FractionBits = 8;
   // quotient bits produced by the divider chain; numerator is 2*(|a| << F) + |b|,
   // so its magnitude needs WordWidth + FractionBits + 1 bits
   localparam int NumWidth     = WordWidth + FractionBits + 1;
   localparam int DenWidth     = WordWidth + 1;
   localparam int ProdWidth    = 2 * WordWidth;

   typedef enum logic [3:0] {
      OpAdd, OpSub, OpMul, OpDiv, OpGt, OpLt, OpGe, OpLe,
      OpEq, OpNe, OpMin, OpMax, OpInc, OpDec, OpToInt, OpFromInt
   } op_type;

   // Record handed from one cell to the next every cycle in which the pipeline advances.
   typedef struct packed {
      logic                  valid;
      logic                  is_div;
      logic                  negative;   // sign of quotient
      logic [NumWidth-1:0]   num;        // remaining numerator bits, shifted left
      logic [DenWidth:0]     rem;        // partial remainder
      logic [DenWidth-1:0]   den;        // 2*|b|
      logic [NumWidth-1:0]   quo;        // quotient bits so far
      logic [WordWidth-1:0]  result;     // result for non-divide operations
      logic                  cmp;
      logic                  ovf;
      logic                  dz;
   } stage_type;

   localparam logic signed [WordWidth-1:0] WordMax = {1'b0, {(WordWidth-1){1'b1}}};
   localparam logic signed [WordWidth-1:0] WordMin = {1'b1, {(WordWidth-1){1'b0}}};

endpackage

@@ design/fpa_stream_if.sv @@
// Valid/ready channel carrying one ALU transaction payload.
// Depends on fpa_pkg for widths.
interface fpa_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [3:0]                             operation;
   logic signed [fpa_pkg::WordWidth-1:0]   operand_a;
   logic signed [fpa_pkg::WordWidth-1:0]   operand_b;
   modport source (output valid, operation, operand_a, operand_b, input ready);
   modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fpa_pkg::WordWidth-1:0]   result_value;
   logic                                   compare_true;
   logic                                   overflow_flag;
   logic                                   divide_by_zero;
   modport source (output valid, result_value, compare_true, overflow_flag, divide_by_zero,
                   input ready);
   modport sink   (input valid, result_value, compare_true, overflow_flag, divide_by_zero,
                   output ready);
endinterface

@@ design/fpa_front.sv @@
// Entry stage: decodes the operation, computes all non-divide results and
// the registered 64-bit product, and prepares divider operands. Uses fpa_pkg.
module fpa_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  logic [3:0]                           operation,
   input  logic signed [fpa_pkg::WordWidth-1:0] operand_a,
   input  logic signed [fpa_pkg::WordWidth-1:0] operand_b,
   output fpa_pkg::stage_type                   stage_out
);
   localparam int W = fpa_pkg::WordWidth;
   localparam int F = fpa_pkg::FractionBits;

   // first register: operands and decoded control
   logic              v1_ff, v1_in;
   fpa_pkg::op_type   op1_ff;
   logic signed [W-1:0] a1_ff, b1_ff;
   logic signed [fpa_pkg::ProdWidth-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v1_in;
      end
      if (enable) begin
         op1_ff  <= fpa_pkg::op_type'(operation);
         a1_ff   <= operand_a;
         b1_ff   <= operand_b;
         prod_ff <= fpa_pkg::ProdWidth'(operand_a) * fpa_pkg::ProdWidth'(operand_b);
      end
   end
   assign v1_in = in_valid;

   function automatic logic signed [W-1:0] sat(input logic signed [W+F+1:0] v,
                                               output logic o);
      begin
         o = 1'b0;
         if (v > (W+F+2)'(fpa_pkg::WordMax)) begin
            o = 1'b1;
            sat = fpa_pkg::WordMax;
         end else if (v < (W+F+2)'(fpa_pkg::WordMin)) begin
            o = 1'b1;
            sat = fpa_pkg::WordMin;
         end else begin
            sat = v[W-1:0];
         end
      end
   endfunction

   logic signed [W+F+1:0] ax, bx;
   logic [fpa_pkg::ProdWidth-1:0] pmag, pround;
   logic pneg;
   logic signed [W+F+1:0] mulx;
   logic [W-1:0] amag, bmag;
   fpa_pkg::stage_type s;
   logic o;

   always_comb begin
      ax   = (W+F+2)'(a1_ff);
      bx   = (W+F+2)'(b1_ff);
      pneg = prod_ff[fpa_pkg::ProdWidth-1];
      pmag = pneg ? -prod_ff : prod_ff;
      pround = (pmag + (fpa_pkg::ProdWidth)'(1 << (F-1))) >> F;
      // |p| <= 2^62; the rounded magnitude is clamped to 2^(W+F), which fits the W+F+2-bit signed mulx
      if (pround > fpa_pkg::ProdWidth'(1) << (W+F)) begin
         mulx = pneg ? -((W+F+2)'(1) << (W+F)) : ((W+F+2)'(1) << (W+F));
      end else begin
         mulx = pneg ? -(W+F+2)'(pround) : (W+F+2)'(pround);
      end
      amag = a1_ff[W-1] ? W'(-a1_ff) : W'(a1_ff);
      bmag = b1_ff[W-1] ? W'(-b1_ff) : W'(b1_ff);

      s          = '0;
      s.valid    = v1_ff;
      s.negative = a1_ff[W-1] ^ b1_ff[W-1];
      // 2n + d over 2d gives the quotient rounded half away from zero
      s.num      = fpa_pkg::NumWidth'({amag, {F{1'b0}}, 1'b0}) + fpa_pkg::NumWidth'(bmag);
      s.den      = {bmag, 1'b0};
      o          = 1'b0;
      unique case (op1_ff)
         fpa_pkg::OpAdd:     begin s.result = sat(ax + bx, o); s.ovf = o; end
         fpa_pkg::OpSub:     begin s.result = sat(ax - bx, o); s.ovf = o; end
         fpa_pkg::OpMul:     begin s.result = sat(mulx, o); s.ovf = o; end
         fpa_pkg::OpDiv: begin
            if (b1_ff == '0) begin
               s.dz     = 1'b1;
               s.result = a1_ff[W-1] ? fpa_pkg::WordMin : fpa_pkg::WordMax;
            end else begin
               s.is_div = 1'b1;
            end
         end
         fpa_pkg::OpGt:      s.cmp = a1_ff > b1_ff;
         fpa_pkg::OpLt:      s.cmp = a1_ff < b1_ff;
         fpa_pkg::OpGe:      s.cmp = a1_ff >= b1_ff;
         fpa_pkg::OpLe:      s.cmp = a1_ff <= b1_ff;
         fpa_pkg::OpEq:      s.cmp = a1_ff == b1_ff;
         fpa_pkg::OpNe:      s.cmp = a1_ff != b1_ff;
         fpa_pkg::OpMin:     s.result = (a1_ff < b1_ff) ? a1_ff : b1_ff;
         fpa_pkg::OpMax:     s.result = (a1_ff > b1_ff) ? a1_ff : b1_ff;
         fpa_pkg::OpInc:     begin s.result = sat(ax + 1, o); s.ovf = o; end
         fpa_pkg::OpDec:     begin s.result = sat(ax - 1, o); s.ovf = o; end
         fpa_pkg::OpToInt:   s.result = a1_ff >>> F;
         fpa_pkg::OpFromInt: begin s.result = sat(ax <<< F, o); s.ovf = o; end
         default:            s.result = '0;
      endcase
   end

   assign stage_out = s;
endmodule

@@ design/fpa_div_cell.sv @@
// One restoring-division cell: takes one numerator bit per cycle while enabled and hands
// the updated record to its neighbour. Uses fpa_pkg::stage_type.
module fpa_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  fpa_pkg::stage_type stage_in,
   output fpa_pkg::stage_type stage_out
);
   localparam int D = fpa_pkg::DenWidth;
   localparam int N = fpa_pkg::NumWidth;

   fpa_pkg::stage_type s_ff, s_in;
   logic [D:0] trial;
   logic [D+1:0] diff;

   always_comb begin
      s_in  = stage_in;
      trial = {stage_in.rem[D-1:0], stage_in.num[N-1]};
      diff  = {1'b0, trial} - {2'b00, stage_in.den};
      s_in.num = {stage_in.num[N-2:0], 1'b0};
      if (!diff[D+1]) begin
         s_in.rem = diff[D:0];
         s_in.quo = {stage_in.quo[N-2:0], 1'b1};
      end else begin
         s_in.rem = trial;
         s_in.quo = {stage_in.quo[N-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff.valid <= 1'b0;
      end else if (enable) begin
         s_ff.valid <= s_in.valid;
      end
      if (enable) begin
         s_ff.is_div   <= s_in.is_div;
         s_ff.negative <= s_in.negative;
         s_ff.num      <= s_in.num;
         s_ff.rem      <= s_in.rem;
         s_ff.den      <= s_in.den;
         s_ff.quo      <= s_in.quo;
         s_ff.result   <= s_in.result;
         s_ff.cmp      <= s_in.cmp;
         s_ff.ovf      <= s_in.ovf;
         s_ff.dz       <= s_in.dz;
      end
   end

   assign stage_out = s_ff;
endmodule

@@ design/fixed_point_alu.sv @@
// Q24.8 fixed-point ALU: add, sub, mul, div (rounded half away from zero),
// comparisons, min/max, inc/dec and integer conversions, saturating on overflow.
// One transaction is accepted every cycle in which the pipeline advances;
// results are presented in order after passing through one entry register,
// the chain of one-bit division cells that every transaction passes through
// and then the output register. The whole pipeline advances only when the
// output register is free or being read.
module fixed_point_alu (
   input  logic       clock,
   input  logic       reset,
   fpa_req_if.sink    req,
   fpa_rsp_if.source  rsp
);
   localparam int N = fpa_pkg::NumWidth;
   localparam int W = fpa_pkg::WordWidth;

   logic enable;
   fpa_pkg::stage_type chain [0:N];

   assign enable    = !rsp.valid || rsp.ready;
   assign req.ready = enable;

   fpa_front u_front (
      .clock, .reset, .enable,
      .in_valid  (req.valid),
      .operation (req.operation),
      .operand_a (req.operand_a),
      .operand_b (req.operand_b),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock, .reset, .enable,
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // quotient = floor((2n + d) / 2d), already rounded; apply sign, saturate
   fpa_pkg::stage_type last;
   logic [N-1:0] q;
   logic signed [W-1:0] res_in, res_ff;
   logic cmp_ff, ovf_ff, dz_ff, valid_ff;
   logic ovf_in;

   always_comb begin
      last   = chain[N];
      q      = last.quo;
      res_in = last.result;
      ovf_in = last.ovf;
      if (last.is_div) begin
         if (!last.negative && q > N'(fpa_pkg::WordMax)) begin
            res_in = fpa_pkg::WordMax; ovf_in = 1'b1;
         end else if (last.negative && q > N'({1'b1, {(W-1){1'b0}}})) begin
            res_in = fpa_pkg::WordMin; ovf_in = 1'b1;
         end else begin
            res_in = last.negative ? -W'(q) : W'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= last.valid;
      end
      if (enable) begin
         res_ff <= res_in;
         cmp_ff <= last.cmp;
         ovf_ff <= ovf_in;
         dz_ff  <= last.dz;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.result_value   = res_ff;
   assign rsp.compare_true   = cmp_ff;
   assign rsp.overflow_flag  = ovf_ff;
   assign rsp.divide_by_zero = dz_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value))
      else $error("result changed under stall");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.divide_by_zero && rsp.overflow_flag))
      else $error("divide-by-zero with overflow");
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.compare_true |-> rsp.result_value == '0)
      else $error("comparison with nonzero value");
`endif
endmodule
